// File: rtl/core/ddps_pkg.sv
// ----------------------------------------------------------------------------
// ddps_pkg
// Shared constants, types and helpers for the differential-drive pose step.
// ----------------------------------------------------------------------------
package ddps_pkg;

    localparam int CORDIC_STEPS = 16;

    // angles in Q16.16
    localparam logic signed [20:0] TWO_PI  = 21'sd411775;
    localparam logic signed [20:0] PI      = 21'sd205887;
    localparam logic signed [20:0] HALF_PI = 21'sd102944;

    // floor(2^40 / (2*pi in Q16.16))
    localparam logic [21:0] RECIP_TWO_PI = 22'd2670175;

    // gain-compensated unit vector, Q2.30
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [1:0] CFG_SPEED_GAIN = 2'd1;
    localparam logic [1:0] CFG_TURN_GAIN  = 2'd2;

    typedef struct packed {
        logic               neg;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [19:0] z;
    } t_rot;

    function automatic logic signed [19:0] atan_q16(input int step);
        logic signed [19:0] a;
        case (step)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            default: a = 20'sd2;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/ddps_cordic_stage.sv
// ----------------------------------------------------------------------------
// ddps_cordic_stage
// One registered rotation-mode CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module ddps_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  ddps_pkg::t_rot i_rot,
    output ddps_pkg::t_rot o_rot
);
    import ddps_pkg::*;

    logic signed [33:0] xs;
    logic signed [33:0] ys;
    t_rot               n_rot;
    t_rot               r_rot;

    assign xs = i_rot.x >>> STEP;
    assign ys = i_rot.y >>> STEP;

    always_comb begin
        n_rot.neg = i_rot.neg;
        if (i_rot.z >= 20'sd0) begin
            n_rot.x = i_rot.x - ys;
            n_rot.y = i_rot.y + xs;
            n_rot.z = i_rot.z - atan_q16(STEP);
        end else begin
            n_rot.x = i_rot.x + ys;
            n_rot.y = i_rot.y - xs;
            n_rot.z = i_rot.z + atan_q16(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_rot = r_rot;

endmodule

// File: rtl/core/diff_drive_pose_step.sv
// ----------------------------------------------------------------------------
// diff_drive_pose_step
// One Euler step of differential-drive kinematics in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse i_start with a pose (Q16.16) and two wheel drives (Q8.8). o_busy is
//   always low: a transaction is taken in every cycle that i_start is high.
//   The pipeline registers angle reduction and gain products, then has 16
//   CORDIC stages (one micro-rotation each), rounding, the speed multiply
//   and the final add with saturation. Throughput is one item per cycle.
//   The result appears on o_next_* for one cycle with o_valid high; the
//   receiver cannot stall, so nothing holds the pipeline.
//   Configuration: i_cfg_index selects time_step (0), speed_gain (1) or
//   turn_gain (2); o_cfg_ready is always high; index 3 is ignored. Write
//   only while no transaction is in flight.
//   Reset (synchronous, active low) flushes all in-flight transactions and
//   loads the register defaults 655, 2048 and 4096.
// ----------------------------------------------------------------------------
module diff_drive_pose_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [31:0] i_pose_yaw,
    input  logic signed [15:0] i_left_drive,
    input  logic signed [15:0] i_right_drive,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_next_x,
    output logic signed [31:0] o_next_y,
    output logic signed [31:0] o_next_yaw
);
    import ddps_pkg::*;

    localparam int LAT = 23;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] yaw;
        logic signed [29:0] v;
        logic signed [33:0] dyaw;
    } t_side;

    // configuration
    logic [15:0]        r_dt;
    logic signed [15:0] r_k;
    logic signed [15:0] r_kw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= 16'd655;
            r_k  <= 16'sd2048;
            r_kw <= 16'sd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIME_STEP:  r_dt <= i_cfg_data;
                CFG_SPEED_GAIN: r_k  <= $signed(i_cfg_data);
                CFG_TURN_GAIN:  r_kw <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // valid shift
    logic [LAT:1] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], i_start};
        end
    end

    logic signed [16:0] dts;
    assign dts = $signed({1'b0, r_dt});

    // stage 1
    logic signed [31:0] r1_px, r1_py, r1_yaw;
    logic signed [16:0] r1_sum, r1_dif;
    logic signed [54:0] r1_prod;
    always_ff @(posedge i_clk) begin
        r1_px   <= i_pose_x;
        r1_py   <= i_pose_y;
        r1_yaw  <= i_pose_yaw;
        r1_sum  <= 17'(i_left_drive) + 17'(i_right_drive);
        r1_dif  <= 17'(i_left_drive) - 17'(i_right_drive);
        r1_prod <= 55'(i_pose_yaw) * 55'($signed({1'b0, RECIP_TWO_PI}));
    end

    // stage 2
    logic signed [31:0] r2_px, r2_py, r2_yaw;
    logic signed [16:0] r2_dif;
    logic signed [34:0] r2_qc;
    logic signed [32:0] r2_ks;
    logic signed [31:0] r2_kk;
    logic signed [14:0] q;
    assign q = r1_prod[54:40];
    always_ff @(posedge i_clk) begin
        r2_px  <= r1_px;
        r2_py  <= r1_py;
        r2_yaw <= r1_yaw;
        r2_dif <= r1_dif;
        r2_qc  <= 35'(q) * 35'(TWO_PI);
        r2_ks  <= 33'(r_k) * 33'(r1_sum);
        r2_kk  <= 32'(r_kw) * 32'(r_k);
    end

    // stage 3
    logic signed [31:0] r3_px, r3_py, r3_yaw;
    logic signed [20:0] r3_r;
    logic signed [49:0] r3_kv;
    logic signed [48:0] r3_p2;
    logic signed [35:0] rem;
    assign rem = 36'(r2_yaw) - 36'(r2_qc);
    always_ff @(posedge i_clk) begin
        r3_px  <= r2_px;
        r3_py  <= r2_py;
        r3_yaw <= r2_yaw;
        r3_r   <= rem[20:0];
        r3_kv  <= 50'(r2_ks) * 50'(dts);
        r3_p2  <= 49'(r2_kk) * 49'(r2_dif);
    end

    // stage 4: finish the reduction and fold into [-pi/2, pi/2]
    logic signed [20:0] ra, rb, rc;
    logic               fneg;
    always_comb begin
        if (r3_r < 21'sd0) begin
            ra = r3_r + TWO_PI;
        end else if (r3_r >= TWO_PI) begin
            ra = r3_r - TWO_PI;
        end else begin
            ra = r3_r;
        end
        rb   = (ra > PI) ? ra - TWO_PI : ra;
        fneg = 1'b0;
        rc   = rb;
        if (rb > HALF_PI) begin
            rc   = rb - PI;
            fneg = 1'b1;
        end else if (rb < -HALF_PI) begin
            rc   = rb + PI;
            fneg = 1'b1;
        end
    end

    logic signed [49:0] kv_rnd;
    logic signed [24:0] p2_hi, p2_lo;
    assign kv_rnd = (r3_kv + 50'sd524288) >>> 20;
    assign p2_hi  = r3_p2[48:24];
    assign p2_lo  = $signed({1'b0, r3_p2[23:0]});

    t_rot               r4_rot;
    logic signed [31:0] r4_px, r4_py, r4_yaw;
    logic signed [29:0] r4_v;
    logic signed [41:0] r4_ph, r4_pl;
    always_ff @(posedge i_clk) begin
        r4_rot.neg <= fneg;
        r4_rot.x   <= CORDIC_X0;
        r4_rot.y   <= '0;
        r4_rot.z   <= rc[19:0];
        r4_px      <= r3_px;
        r4_py      <= r3_py;
        r4_yaw     <= r3_yaw;
        r4_v       <= kv_rnd[29:0];
        r4_ph      <= 42'(p2_hi) * 42'(dts);
        r4_pl      <= 42'(p2_lo) * 42'(dts);
    end

    logic signed [65:0] p3;
    logic signed [65:0] dyaw_full;
    assign p3        = (66'(r4_ph) <<< 24) + 66'(r4_pl);
    assign dyaw_full = (p3 + 66'sd2147483648) >>> 32;

    // CORDIC stages with side data alongside
    t_rot  rot [CORDIC_STEPS+1];
    t_side r_side [CORDIC_STEPS];

    assign rot[0] = r4_rot;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        ddps_cordic_stage #(.STEP(g)) u_stage (
            .i_clk (i_clk),
            .i_rot (rot[g]),
            .o_rot (rot[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        r_side[0].px   <= r4_px;
        r_side[0].py   <= r4_py;
        r_side[0].yaw  <= r4_yaw;
        r_side[0].v    <= r4_v;
        r_side[0].dyaw <= dyaw_full[33:0];
        for (int j = 1; j < CORDIC_STEPS; j++) begin
            r_side[j] <= r_side[j-1];
        end
    end

    // stage 21: round to Q16.16 and apply the fold sign
    t_rot               rf;
    logic signed [33:0] cx, sy;
    assign rf = rot[CORDIC_STEPS];
    assign cx = (rf.x + 34'sd8192) >>> 14;
    assign sy = (rf.y + 34'sd8192) >>> 14;

    logic signed [19:0] r21_c, r21_s;
    t_side              r21_side;
    always_ff @(posedge i_clk) begin
        r21_c    <= rf.neg ? -cx[19:0] : cx[19:0];
        r21_s    <= rf.neg ? -sy[19:0] : sy[19:0];
        r21_side <= r_side[CORDIC_STEPS-1];
    end

    // stage 22: speed times cos/sin, yaw update
    logic signed [49:0] r22_vc, r22_vs;
    logic signed [31:0] r22_px, r22_py, r22_yaw;
    always_ff @(posedge i_clk) begin
        r22_vc  <= 50'(r21_side.v) * 50'(r21_c);
        r22_vs  <= 50'(r21_side.v) * 50'(r21_s);
        r22_px  <= r21_side.px;
        r22_py  <= r21_side.py;
        r22_yaw <= sat32(35'(r21_side.yaw) + 35'(r21_side.dyaw));
    end

    // stage 23: position update and output
    logic signed [49:0] dx, dy;
    assign dx = (r22_vc + 50'sd32768) >>> 16;
    assign dy = (r22_vs + 50'sd32768) >>> 16;

    always_ff @(posedge i_clk) begin
        o_next_x   <= sat32(35'(r22_px) + 35'($signed(dx[33:0])));
        o_next_y   <= sat32(35'(r22_py) + 35'($signed(dy[33:0])));
        o_next_yaw <= r22_yaw;
    end

    assign o_valid = r_vld[LAT];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##23 o_valid)
        else $error("result missing after pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 23))
        else $error("result without a matching transaction");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

// File: tb/ddps_checker.sv
// ----------------------------------------------------------------------------
// ddps_checker
// Watches the pose-step channels, predicts each next pose with a local model
// of the fixed-point kinematics and compares results in order.
// ----------------------------------------------------------------------------
module ddps_checker
    import ddps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic signed [31:0] i_pose_yaw,
    input  logic signed [15:0] i_left_drive,
    input  logic signed [15:0] i_right_drive,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic signed [31:0] i_next_x,
    input  logic signed [31:0] i_next_y,
    input  logic signed [31:0] i_next_yaw,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] yaw;
    } t_pose;

    t_pose pose_q[$];
    logic [15:0]        dt_reg;
    logic signed [15:0] kv_reg;
    logic signed [15:0] kw_reg;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_pose next_pose(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pyaw,
                                        logic signed [15:0] l, logic signed [15:0] r);
        longint ang, cx, cy, cz, xs, ys, v, dyaw, two_pi, pi_q, half_pi;
        longint atans[16];
        logic flip;
        t_pose p;
        atans = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                  256, 128, 64, 32, 16, 8, 4, 2};
        two_pi = 411775;
        pi_q = 205887;
        half_pi = 102944;
        flip = 1'b0;
        ang = longint'(pyaw) % two_pi;
        if (ang < 0) ang += two_pi;
        if (ang > pi_q) ang -= two_pi;
        if (ang > half_pi) begin
            ang -= pi_q;
            flip = 1'b1;
        end else if (ang < -half_pi) begin
            ang += pi_q;
            flip = 1'b1;
        end
        cx = 652032874;
        cy = 0;
        cz = ang;
        for (int i = 0; i < 16; i++) begin
            xs = floor_shift(cx, i);
            ys = floor_shift(cy, i);
            if (cz >= 0) begin
                cx -= ys; cy += xs; cz -= atans[i];
            end else begin
                cx += ys; cy -= xs; cz += atans[i];
            end
        end
        cx = round_shift(cx, 14);
        cy = round_shift(cy, 14);
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        v = round_shift(longint'(kv_reg) * (longint'(l) + longint'(r))
                        * longint'({1'b0, dt_reg}), 20);
        dyaw = round_shift(longint'(kw_reg) * longint'(kv_reg) * (longint'(l) - longint'(r))
                           * longint'({1'b0, dt_reg}), 32);
        p.x = 32'(clamp32(longint'(px) + round_shift(v * cx, 16)));
        p.y = 32'(clamp32(longint'(py) + round_shift(v * cy, 16)));
        p.yaw = 32'(clamp32(longint'(pyaw) + dyaw));
        return p;
    endfunction

    assign o_pending = pose_q.size();

    always @(posedge i_clk) begin
        t_pose e;
        if (!i_rst_n) begin
            dt_reg <= 16'd655;
            kv_reg <= 16'sd2048;
            kw_reg <= 16'sd4096;
            pose_q.delete();
            o_errors <= 0;
        end else begin
            if (i_start && !i_busy) begin
                pose_q.push_back(next_pose(i_pose_x, i_pose_y, i_pose_yaw,
                                           i_left_drive, i_right_drive));
            end
            if (i_valid) begin
                if (pose_q.size() == 0) begin
                    $error("result with no transaction pending");
                    o_errors <= o_errors + 1;
                end else begin
                    e = pose_q.pop_front();
                    if (i_next_x !== e.x || i_next_y !== e.y || i_next_yaw !== e.yaw) begin
                        o_errors <= o_errors + 1;
                        if (i_next_x !== e.x)
                            $error("next_x exp %0d got %0d", e.x, i_next_x);
                        if (i_next_y !== e.y)
                            $error("next_y exp %0d got %0d", e.y, i_next_y);
                        if (i_next_yaw !== e.yaw)
                            $error("next_yaw exp %0d got %0d", e.yaw, i_next_yaw);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TIME_STEP:  dt_reg <= i_cfg_data;
                    CFG_SPEED_GAIN: kv_reg <= i_cfg_data;
                    CFG_TURN_GAIN:  kw_reg <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: tb/tb_diff_drive_pose_step.sv
// ----------------------------------------------------------------------------
// tb_diff_drive_pose_step
// Drives poses and wheel drives through several gain settings and idle
// patterns; the checker predicts and compares every next pose.
// ----------------------------------------------------------------------------
module tb_diff_drive_pose_step;
    timeunit 1ns;
    timeprecision 1ps;
    import ddps_pkg::*;

    localparam int WATCHDOG = 5000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] pose_x, pose_y, pose_yaw;
    logic signed [15:0] left_drive, right_drive;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               res_valid;
    logic signed [31:0] next_x, next_y, next_yaw;
    int                 errors;
    int                 pending;
    int                 quiet_cycles;
    int                 idle_pct;

    diff_drive_pose_step dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_pose_x(pose_x), .i_pose_y(pose_y), .i_pose_yaw(pose_yaw),
        .i_left_drive(left_drive), .i_right_drive(right_drive),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(res_valid), .o_next_x(next_x), .o_next_y(next_y), .o_next_yaw(next_yaw)
    );

    ddps_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_pose_x(pose_x), .i_pose_y(pose_y), .i_pose_yaw(pose_yaw),
        .i_left_drive(left_drive), .i_right_drive(right_drive),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(res_valid), .i_next_x(next_x), .i_next_y(next_y), .i_next_yaw(next_yaw),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("tb_diff_drive_pose_step: done, errors");
                $finish;
            end
        end
    end

    task automatic send_pose(logic [31:0] x, logic [31:0] y, logic [31:0] yaw,
                             logic [15:0] l, logic [15:0] r);
        cfg_valid <= 1'b0;
        while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pose_x <= x;
        pose_y <= y;
        pose_yaw <= yaw;
        left_drive <= l;
        right_drive <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return $urandom_range(3, 0) == 0 ? 32'h7FFFFFF0 + $urandom_range(15, 0)
                                                 : 32'h80000000 + $urandom_range(15, 0);
            default: return 32'($signed($urandom_range(2000000, 0)) - 1000000);
        endcase
    endfunction

    function automatic logic [31:0] rand_yaw();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return 32'($urandom_range(8, 0)) * 32'd51472 + $urandom_range(2, 0) - 1;
            default: return 32'($signed($urandom_range(1700000, 0)) - 850000);
        endcase
    endfunction

    function automatic logic [15:0] rand_drive();
        case ($urandom_range(3, 0))
            0: return $urandom();
            1: return $urandom_range(1, 0) ? 16'h7FFF : 16'h8000;
            default: return 16'($signed($urandom_range(1024, 0)) - 512);
        endcase
    endfunction

    task automatic random_phase(int count, int pct);
        idle_pct = pct;
        repeat (count) send_pose(rand_coord(), rand_coord(), rand_yaw(),
                                 rand_drive(), rand_drive());
        idle_pct = 0;
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        pose_x = '0; pose_y = '0; pose_yaw = '0;
        left_drive = '0; right_drive = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        idle_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset gains, angle quadrants, field extremes
        send_pose(0, 0, 0, 16'h0100, 16'h0100);
        send_pose(0, 0, 32'd102944, 16'h0100, 16'h0080);
        send_pose(0, 0, 32'd102945, 16'h0080, 16'h0100);
        send_pose(0, 0, 32'd205887, 16'h0200, 16'h0200);
        send_pose(0, 0, -32'sd205888, 16'h0200, 16'h0200);
        send_pose(0, 0, 32'd411775, 16'hFF00, 16'h0100);
        send_pose(0, 0, -32'sd102945, 16'h7FFF, 16'h8000);
        send_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF);
        send_pose(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000);
        send_pose(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 16'hFFFF, 16'h0001);
        drain();

        // extreme gains, then unknown register index
        write_reg(CFG_TIME_STEP, 16'hFFFF);
        write_reg(CFG_SPEED_GAIN, 16'h7FFF);
        write_reg(CFG_TURN_GAIN, 16'h8000);
        write_reg(2'd3, 16'h1234);
        send_pose(32'h7FFFFFF0, 32'h80000010, 32'h7FFFFFFF, 16'h7FFF, 16'h8000);
        send_pose(32'h80000010, 32'h7FFFFFF0, 32'h80000000, 16'h8000, 16'h7FFF);
        send_pose(0, 0, 32'd51472, 16'h7FFF, 16'h7FFF);
        send_pose(0, 0, -32'sd51472, 16'h8000, 16'h8000);
        random_phase(80, 0);
        drain();

        write_reg(CFG_TIME_STEP, 16'h0000);
        write_reg(CFG_SPEED_GAIN, 16'h8000);
        write_reg(CFG_TURN_GAIN, 16'h7FFF);
        random_phase(40, 81);
        drain();

        write_reg(CFG_TIME_STEP, 16'd655);
        write_reg(CFG_SPEED_GAIN, 16'h8000);
        write_reg(CFG_TURN_GAIN, 16'h8000);
        random_phase(100, 14);
        drain();

        write_reg(CFG_TIME_STEP, 16'($urandom()));
        write_reg(CFG_SPEED_GAIN, 16'($urandom()));
        write_reg(CFG_TURN_GAIN, 16'($urandom()));
        random_phase(100, 0);
        drain();

        write_reg(CFG_TIME_STEP, 16'h0001);
        write_reg(CFG_SPEED_GAIN, 16'h0000);
        write_reg(CFG_TURN_GAIN, 16'h0000);
        random_phase(30, 81);
        drain();

        write_reg(CFG_TIME_STEP, 16'd6554);
        write_reg(CFG_SPEED_GAIN, 16'd4096);
        write_reg(CFG_TURN_GAIN, 16'd4096);
        random_phase(100, 14);
        drain();

        if (errors == 0) begin
            $display("tb_diff_drive_pose_step: done, clean");
        end else begin
            $display("tb_diff_drive_pose_step: done, errors");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/ddps_pkg.sv
rtl/core/ddps_cordic_stage.sv
rtl/core/diff_drive_pose_step.sv
tb/ddps_checker.sv
tb/tb_diff_drive_pose_step.sv
